/* rtl/sorted_priority_queue_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// expression holds at every clock edge outside reset
`define SPQ_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, command and status codes, and default sizing.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    // command codes
    localparam logic [0:0] CMD_PUSH = 1'b0;
    localparam logic [0:0] CMD_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // value returned by a pop on an empty queue
    localparam value_t POP_EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [0:0] command;
        value_t     value;
    } spq_in_t;

    typedef struct packed {
        value_t             popped_value;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } spq_out_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        value_t value;
    } spq_op_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   ge;
        value_t entry;
    } spq_slot_t;

endpackage

/* rtl/sorted_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue, top level
// Bounded queue of signed values kept in a chain of cells, largest first.
// Push inserts in order, pop returns the largest; one result per item.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  s_       | in        | s_valid / s_ready  | spq_in_t  (command, value)
//  m_       | out       | m_valid / m_ready  | spq_out_t (popped_value, status,
//           |           |                    |            entry_count)
//
//  One item per cycle while s_ready is high: the whole chain updates at the edge that accepts it.
//  The result is written into an output register at that same edge.
//  s_ready is high while that register is empty or being taken.
//  Reset (aresetn low, synchronous) empties the chain; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spq_pkg::spq_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;
    `include "sorted_priority_queue_top_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    spq_out_t         m_data_reg;
    spq_out_t         m_data_next;

    logic             s_fire;
    logic             is_pop;
    logic             full;
    logic             empty;
    spq_op_t          op;
    spq_slot_t        slots [CAPACITY];
    spq_slot_t        head_left;
    spq_slot_t        tail_right;
    logic [CAPACITY-1:0] valid_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign is_pop  = (s_data.command == CMD_POP);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // broadcast the operation to the chain
    assign op.push  = s_fire && !is_pop && !full;
    assign op.pop   = s_fire && is_pop && !empty;
    assign op.value = s_data.value;

    // chain ends: the head always counts as kept, the tail feeds nothing
    assign head_left.valid  = 1'b1;
    assign head_left.ge     = 1'b1;
    assign head_left.entry  = '0;
    assign tail_right.valid = 1'b0;
    assign tail_right.ge    = 1'b0;
    assign tail_right.entry = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_slot_t left_s;
        spq_slot_t right_s;
        if (i == 0) begin : g_head
            assign left_s = head_left;
        end else begin : g_mid_l
            assign left_s = slots[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_s = tail_right;
        end else begin : g_mid_r
            assign right_s = slots[i+1];
        end
        spq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (op),
            .left    (left_s),
            .right   (right_s),
            .slot    (slots[i])
        );
        assign valid_vec[i] = slots[i].valid;
    end

    // build the result and the next count
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next             = 1'b1;
            m_data_next.popped_value = '0;
            m_data_next.status       = ST_OK;
            if (is_pop) begin
                if (empty) begin
                    m_data_next.popped_value = POP_EMPTY_VALUE;
                    m_data_next.status       = ST_EMPTY;
                end else begin
                    m_data_next.popped_value = slots[0].entry;
                    count_next               = count_reg - 1'b1;
                end
            end else begin
                if (full) begin
                    m_data_next.status = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            m_data_next.entry_count = COUNT_W'(count_next);
        end
    end

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SPQ_ASSERT_ALWAYS(a_count_matches, aclk, aresetn, $countones(valid_vec) == count_reg, "count differs from occupied cells")
    `SPQ_ASSERT_ALWAYS(a_chain_packed, aclk, aresetn, (valid_vec & CAPACITY'(valid_vec + 1'b1)) == '0, "occupied cells not packed at head")
    `SPQ_ASSERT_NEXT(a_pop_empty, aclk, aresetn, s_fire && is_pop && empty, m_valid && m_data.status == ST_EMPTY, "pop on empty queue without empty status")
    `SPQ_ASSERT_NEXT(a_push_count, aclk, aresetn, op.push, count_reg == $past(count_reg) + 1'b1, "push did not grow count")

endmodule

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the descending chain; compares against the broadcast
// value and takes its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  spq_pkg::spq_op_t   op,
    input  spq_pkg::spq_slot_t left,
    input  spq_pkg::spq_slot_t right,
    output spq_pkg::spq_slot_t slot
);
    import spq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t entry_reg;
    value_t entry_next;
    logic   ge;

    // keep this entry on a push when it is at least the new value
    assign ge = valid_reg && (entry_reg >= op.value);

    // pick the next entry
    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (op.pop) begin
            valid_next = right.valid;
            entry_next = right.entry;
        end else if (op.push && !ge) begin
            if (left.ge) begin
                valid_next = 1'b1;
                entry_next = op.value;
            end else begin
                valid_next = left.valid;
                entry_next = left.entry;
            end
        end
    end

    // hold valid under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // advance the entry
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign slot.valid = valid_reg;
    assign slot.ge    = ge;
    assign slot.entry = entry_reg;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends push and pop items with random input gaps and result stalls. A shadow
// copy of the sorted store predicts random results; a short table of directed
// items with their own results runs first. All are compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int     RUN_ITEMS   = 850;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     IDLE_PCT    = 34;
    localparam int     REPORT_MAX  = 10;
    localparam value_t V_MAX       = 32'sh7fffffff;
    localparam value_t V_MIN       = 32'sh80000000;

    typedef struct {
        spq_in_t  stim;
        bit       typed;
        spq_out_t want;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    spq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    spq_out_t m_data;

    // shadow of the stored values, ascending
    value_t   held_values[$];
    spq_out_t pending_results[$];
    dir_row_t dir_rows[$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;
    bit       steady       = 1'b0;

    sorted_priority_queue_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Apply one push or pop to the shadow store and return its result
    function automatic spq_out_t predict_queue_op(spq_in_t it);
        spq_out_t r;
        int       pos;
        r = '{popped_value: '0, status: ST_OK, entry_count: '0};
        if (it.command == CMD_PUSH) begin
            if (held_values.size() >= SPQ_CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // insert after every smaller value, before equal ones
                pos = 0;
                while (pos < held_values.size() &&
                       $signed(held_values[pos]) < $signed(it.value))
                    pos++;
                held_values.insert(pos, it.value);
            end
        end else if (held_values.size() == 0) begin
            r.popped_value = POP_EMPTY_VALUE;
            r.status       = ST_EMPTY;
        end else begin
            r.popped_value = held_values.pop_back();
        end
        r.entry_count = COUNT_W'(held_values.size());
        return r;
    endfunction

    // Favor extremes and a narrow band around zero so duplicates are common
    function automatic value_t pick_value();
        case ($urandom_range(9))
            0:       return V_MAX;
            1:       return V_MIN;
            2, 3:    return value_t'(int'($urandom_range(6)) - 3);
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic add_row(logic [0:0] cmd, value_t v, bit typed, spq_out_t want);
        dir_row_t row;
        row.stim  = '{command: cmd, value: v};
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then record its expected result
    task automatic send_item(spq_in_t it, bit typed, spq_out_t want);
        spq_out_t guess;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        guess = predict_queue_op(it);
        pending_results.push_back(typed ? want : guess);
    endtask

    // Check each taken result against the oldest expectation; stall at random
    always @(posedge aclk) begin
        spq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d unexpected: value %0d status %0d count %0d",
                             results_seen, m_data.popped_value, m_data.status,
                             m_data.entry_count);
            end else begin
                want = pending_results.pop_front();
                if (m_data.popped_value !== want.popped_value ||
                    m_data.status !== want.status ||
                    m_data.entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d mismatch: exp %0d/%0d/%0d, got %0d/%0d/%0d",
                                 results_seen, want.popped_value, want.status,
                                 want.entry_count, m_data.popped_value, m_data.status,
                                 m_data.entry_count);
                end
            end
        end
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_priority_queue_top verification failed");
            $finish;
        end
    end

    initial begin
        value_t  fill_vals[16];
        spq_in_t it;
        int      sent;
        int      kind;
        int      run_len;
        int      push_pct;

        fill_vals = '{32'sd0, -32'sd1, 32'sd1, V_MAX, V_MIN, 32'sd0, 32'sd5, -32'sd5,
                      V_MAX, 32'sh12345678, -32'sh12345678, 32'sd7, 32'sd7,
                      32'sh55555555, 32'shaaaaaaaa, 32'sd2};

        // Directed: pop while empty, extremes in both orders, fill to full,
        // push while full, then pop the largest of the full store
        add_row(CMD_POP,  32'sd0, 1'b1, '{POP_EMPTY_VALUE, ST_EMPTY, COUNT_W'(0)});
        add_row(CMD_PUSH, V_MAX,  1'b1, '{32'sd0, ST_OK, COUNT_W'(1)});
        add_row(CMD_PUSH, V_MIN,  1'b1, '{32'sd0, ST_OK, COUNT_W'(2)});
        add_row(CMD_POP,  V_MIN,  1'b1, '{V_MAX, ST_OK, COUNT_W'(1)});
        add_row(CMD_POP,  V_MAX,  1'b1, '{V_MIN, ST_OK, COUNT_W'(0)});
        for (int i = 0; i < 16; i++)
            add_row(CMD_PUSH, fill_vals[i], 1'b1, '{32'sd0, ST_OK, COUNT_W'(i + 1)});
        add_row(CMD_PUSH, 32'sd3, 1'b1, '{32'sd0, ST_FULL, COUNT_W'(SPQ_CAPACITY)});
        add_row(CMD_POP,  32'sd0, 1'b1, '{V_MAX, ST_OK, COUNT_W'(SPQ_CAPACITY - 1)});

        // Hold reset, then release it at an edge
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        // Random runs: fill bursts, drain bursts and mixed stretches
        sent = 0;
        while (sent < RUN_ITEMS) begin
            kind    = $urandom_range(9);
            run_len = $urandom_range(1, 20);
            if (kind <= 3)
                push_pct = 90;
            else if (kind <= 6)
                push_pct = 10;
            else
                push_pct = 50;
            repeat (run_len) begin
                steady     = (sent >= 300 && sent < 450);
                it.value   = pick_value();
                it.command = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        // Drain the outstanding results, then allow a few trailing cycles
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("sorted_priority_queue_top verification clean");
        else
            $display("sorted_priority_queue_top verification failed");
        $finish;
    end

endmodule
